FILE: hdl/rrqs_pkg.sv
// Shared types and constants for the round-robin quantum scheduler.
// Used by rrqs_ram and round_robin_quantum_scheduler; no dependencies.
`default_nettype none

package rrqs_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 4;
  localparam int BURST_W = 16;

  localparam logic [BURST_W-1:0] QUANTUM_RESET = BURST_W'(10);

  // Register index of the quantum register on the configuration port
  localparam logic REG_QUANTUM = 1'b0;

  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_FULL  = 3'd1,
    ST_ZERO  = 3'd2,
    ST_SLICE = 3'd3,
    ST_IDLE  = 3'd4
  } status_t;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [ID_W-1:0]    id;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/round_robin_quantum_scheduler.sv
// Round-robin scheduler with a fixed time quantum over a FIFO of ready tasks.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle unless the result stream stalls; the head entry is
// kept prefetched from the RAM's registered read port; pop, requeue and push never wait.
// Reset (synchronous): pointers and count cleared, quantum set to 10; the queue
// storage itself is not cleared.
`default_nettype none

module round_robin_quantum_scheduler
  import rrqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // task_id[7:0], task_priority[11:8], burst_length[27:12]
  input  wire logic        s_tuser,   // op[0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // run_task_id[7:0], run_priority[11:8], slice_length[27:12]
  output logic [2:0]       m_tuser,   // status[2:0]
  output logic             m_tlast    // task_done
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = $bits(entry_t);

  // configuration
  logic [BURST_W-1:0] quantum;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg_write && (paddr[2] == REG_QUANTUM)) begin
      quantum <= pwdata[BURST_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_QUANTUM) ? {{(32-BURST_W){1'b0}}, quantum} : 32'd0;

  // input register
  logic   in_valid;
  op_t    in_op;
  entry_t in_entry;
  logic   adv;
  logic   take;

  assign adv      = !m_tvalid || m_tready;
  assign take     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_op    <= op_t'(s_tuser);
      in_entry <= entry_t'(s_tdata[ENTRY_W-1:0]);
    end
  end

  // queue state
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc;
  entry_t        head_data;

  assign head_inc = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  // per-request decision
  logic [BURST_W-1:0] q_eff;
  logic               pop;
  logic               push;
  entry_t             push_entry;
  status_t            res_status;
  entry_t             res_entry;
  logic               res_done;
  logic [CW-1:0]      count_next;

  assign q_eff = (quantum == '0) ? BURST_W'(1) : quantum;

  always_comb begin
    pop        = 1'b0;
    push       = 1'b0;
    push_entry = in_entry;
    res_status = ST_IDLE;
    res_entry  = '0;
    res_done   = 1'b0;
    count_next = count;
    unique case (in_op)
      OP_ADD: begin
        priority if (in_entry.burst == '0) begin
          res_status = ST_ZERO;
        end else if (count == CW'(QUEUE_DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          push       = 1'b1;
          res_status = ST_ADDED;
          count_next = count + 1'b1;
        end
      end
      OP_DISPATCH: begin
        if (count != '0) begin
          pop             = 1'b1;
          res_status      = ST_SLICE;
          res_entry.id    = head_data.id;
          res_entry.prio  = head_data.prio;
          if (head_data.burst <= q_eff) begin
            res_entry.burst = head_data.burst;
            res_done        = 1'b1;
            count_next      = count - 1'b1;
          end else begin
            // requeue the remainder at the tail; the count is unchanged
            res_entry.burst  = q_eff;
            push             = 1'b1;
            push_entry.id    = head_data.id;
            push_entry.prio  = head_data.prio;
            push_entry.burst = head_data.burst - q_eff;
          end
        end
      end
      default: ;
    endcase
  end

  logic          ram_we;
  logic [AW-1:0] ram_raddr;

  assign ram_we    = take && push;
  assign ram_raddr = (take && pop) ? head_inc : head;

  rrqs_ram #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(push_entry),
    .raddr(ram_raddr),
    .rdata(head_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (take) begin
      if (pop) begin
        head <= head_inc;
      end
      if (push) begin
        tail <= tail_inc;
      end
      count <= count_next;
    end
  end

  // result register
  status_t out_status;
  entry_t  out_entry;
  logic    out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
    if (take) begin
      out_status <= res_status;
      out_entry  <= res_entry;
      out_done   <= res_done;
    end
  end

  assign m_tdata = {{(32-ENTRY_W){1'b0}}, out_entry};
  assign m_tuser = out_status;
  assign m_tlast = out_done;

endmodule

`default_nettype wire

FILE: hdl/rrqs_ram.sv
// Ready-queue storage: one write port, one registered read port with
// write-first bypass. Depends on rrqs_pkg for the entry type.
`default_nettype none

module rrqs_ram
  import rrqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // a write landing on the address being read shows up at once
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
